/* rtl/hisd_pkg.sv */
// Shared constants and types for the HART-IP stream deframer.
// No dependencies; imported by hart_ip_stream_deframer.
`timescale 1ns / 1ps

package hisd_pkg;

    localparam int HEADER_BYTES = 8;
    localparam int HDR_IDX_W    = 3;
    localparam int COUNT_W      = 16;

    localparam logic [7:0] TYPE_MASK  = 8'h0F;
    localparam logic [7:0] FLAGS_MASK = 8'hF0;

    typedef enum logic [1:0] {
        KIND_HEADER  = 2'd0,
        KIND_PAYLOAD = 2'd1,
        KIND_SHORT   = 2'd2
    } t_result_kind;

endpackage

/* rtl/hart_ip_stream_deframer.sv */
// Streaming deframer for HART-IP style packets: header decode and payload pass-through.
// Depends on hisd_pkg for the header size, masks and result kind codes.
`timescale 1ns / 1ps

// Takes one stream word per cycle and gives at most one result per word, registered
// in the cycle after the word is accepted. The first seven header words give no
// result; the eighth gives a header result (or a short-count error result with last
// set), and each payload word after it is forwarded with last set on the final one. A
// header whose byte count equals the header size is a complete packet: its header
// result carries last. The input is taken every cycle unless a result is waiting in
// the output register and the consumer stalls; the single output register is the only
// buffering, so sustained rate is one word per cycle.
module hart_ip_stream_deframer (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_valid,
    output logic                    o_stall,
    input  logic [7:0]              i_data_byte,
    output logic                    o_valid,
    input  logic                    i_stall,
    output hisd_pkg::t_result_kind  o_result_kind,
    output logic [7:0]              o_version,
    output logic [3:0]              o_msg_type,
    output logic [3:0]              o_msg_flags,
    output logic [7:0]              o_message_id,
    output logic [7:0]              o_status_code,
    output logic [15:0]             o_transaction_id,
    output logic [15:0]             o_payload_length,
    output logic [7:0]              o_payload_byte,
    output logic                    o_last
);
    import hisd_pkg::*;

    localparam logic [HDR_IDX_W-1:0] LAST_IDX  = HDR_IDX_W'(HEADER_BYTES - 1);
    localparam logic [COUNT_W-1:0]   HDR_COUNT = COUNT_W'(HEADER_BYTES);

    // Parsing state.
    logic                 r_in_payload, n_in_payload;
    logic [HDR_IDX_W-1:0] r_hdr_idx, n_hdr_idx;
    logic [COUNT_W-1:0]   r_bytes_left, n_bytes_left;
    logic [7:0]           r_hdr [HEADER_BYTES-1];

    // Result register.
    logic                 r_out_valid;
    t_result_kind         r_kind, n_kind;
    logic [7:0]           r_version, n_version;
    logic [3:0]           r_msg_type, n_msg_type;
    logic [3:0]           r_msg_flags, n_msg_flags;
    logic [7:0]           r_message_id, n_message_id;
    logic [7:0]           r_status, n_status;
    logic [15:0]          r_trans_id, n_trans_id;
    logic [15:0]          r_pay_len, n_pay_len;
    logic [7:0]           r_pay_byte, n_pay_byte;
    logic                 r_last, n_last;
    logic                 n_has_result;
    logic                 hdr_write;

    logic                 accept;
    logic [COUNT_W-1:0]   count;
    logic [COUNT_W-1:0]   count_minus_hdr;
    logic [COUNT_W-1:0]   bytes_left_dec;

    assign o_stall = r_out_valid && i_stall;
    assign accept  = i_valid && !o_stall;

    assign count           = {r_hdr[HEADER_BYTES-2], i_data_byte};
    assign count_minus_hdr = count - HDR_COUNT;
    assign bytes_left_dec  = r_bytes_left - COUNT_W'(1);

    always_comb begin
        n_in_payload = r_in_payload;
        n_hdr_idx    = r_hdr_idx;
        n_bytes_left = r_bytes_left;
        n_has_result = 1'b0;
        hdr_write    = 1'b0;
        n_kind       = KIND_HEADER;
        n_version    = '0;
        n_msg_type   = '0;
        n_msg_flags  = '0;
        n_message_id = '0;
        n_status     = '0;
        n_trans_id   = '0;
        n_pay_len    = '0;
        n_pay_byte   = '0;
        n_last       = 1'b0;

        if (r_in_payload && (r_bytes_left != '0)) begin
            n_has_result = 1'b1;
            n_kind       = KIND_PAYLOAD;
            n_pay_byte   = i_data_byte;
            n_bytes_left = bytes_left_dec;
            if (bytes_left_dec == '0) begin
                n_last       = 1'b1;
                n_in_payload = 1'b0;
            end
        end else if (r_hdr_idx != LAST_IDX) begin
            n_in_payload = 1'b0;
            hdr_write    = 1'b1;
            n_hdr_idx    = r_hdr_idx + HDR_IDX_W'(1);
        end else begin
            n_in_payload = 1'b0;
            n_hdr_idx    = '0;
            n_has_result = 1'b1;
            n_version    = r_hdr[0];
            n_msg_type   = 4'(r_hdr[1] & TYPE_MASK);
            n_msg_flags  = 4'((r_hdr[1] & FLAGS_MASK) >> 4);
            n_message_id = r_hdr[2];
            n_status     = r_hdr[3];
            n_trans_id   = {r_hdr[4], r_hdr[5]};
            if (count < HDR_COUNT) begin
                n_kind = KIND_SHORT;
                n_last = 1'b1;
            end else begin
                n_kind    = KIND_HEADER;
                n_pay_len = count_minus_hdr;
                if (count == HDR_COUNT) begin
                    n_last = 1'b1;
                end else begin
                    n_bytes_left = count_minus_hdr;
                    n_in_payload = 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_payload <= 1'b0;
            r_hdr_idx    <= '0;
            r_bytes_left <= '0;
            r_out_valid  <= 1'b0;
        end else if (accept) begin
            r_in_payload <= n_in_payload;
            r_hdr_idx    <= n_hdr_idx;
            r_bytes_left <= n_bytes_left;
            r_out_valid  <= n_has_result;
        end else if (!i_stall) begin
            r_out_valid  <= 1'b0;
        end
    end

    // The header store and the result fields carry no reset.
    always_ff @(posedge i_clk) begin
        if (accept && hdr_write) begin
            r_hdr[r_hdr_idx] <= i_data_byte;
        end
        if (accept && n_has_result) begin
            r_kind       <= n_kind;
            r_version    <= n_version;
            r_msg_type   <= n_msg_type;
            r_msg_flags  <= n_msg_flags;
            r_message_id <= n_message_id;
            r_status     <= n_status;
            r_trans_id   <= n_trans_id;
            r_pay_len    <= n_pay_len;
            r_pay_byte   <= n_pay_byte;
            r_last       <= n_last;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_result_kind    = r_kind;
    assign o_version        = r_version;
    assign o_msg_type       = r_msg_type;
    assign o_msg_flags      = r_msg_flags;
    assign o_message_id     = r_message_id;
    assign o_status_code    = r_status;
    assign o_transaction_id = r_trans_id;
    assign o_payload_length = r_pay_len;
    assign o_payload_byte   = r_pay_byte;
    assign o_last           = r_last;

`ifndef SYNTHESIS
    a_payload_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_bytes_left != '0))
        else $error("payload phase with no bytes left");

    a_no_header_mid_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_payload |-> (r_hdr_idx == '0))
        else $error("header index moved during payload");

    a_short_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_SHORT)) |-> (o_last && (o_payload_length == '0)))
        else $error("short-count result without last or with a length");

    a_payload_continues: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_PAYLOAD) && !o_last) |-> r_in_payload)
        else $error("non-final payload word but payload phase ended");

    a_header_opens_payload: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_result_kind == KIND_HEADER) && !o_last) |-> r_in_payload)
        else $error("header with payload did not enter payload phase");
`endif

endmodule

/* tb/tb_hart_ip_stream_deframer.sv */
// Self-checking testbench for hart_ip_stream_deframer: back-to-back packets in, results checked.
// Depends on hisd_pkg (result kinds, header size) and the deframer RTL.
`timescale 1ns / 1ps

module tb_hart_ip_stream_deframer;
    import hisd_pkg::*;

    typedef struct packed {
        t_result_kind kind;
        logic [7:0]   version;
        logic [3:0]   msg_type;
        logic [3:0]   msg_flags;
        logic [7:0]   message_id;
        logic [7:0]   status_code;
        logic [15:0]  transaction_id;
        logic [15:0]  payload_length;
        logic [7:0]   payload_byte;
        logic         last;
    } t_frame_result;

    // Tracks the deframer state word by word and holds the results it must produce.
    class FrameScoreboard;
        logic         in_payload;
        logic [2:0]   hdr_idx;
        logic [7:0]   hdr_store [HEADER_BYTES-1];
        logic [15:0]  bytes_left;
        t_frame_result pending_results [$];
        int           errors;

        function new();
            in_payload = 1'b0;
            hdr_idx    = '0;
            bytes_left = '0;
            errors     = 0;
            foreach (hdr_store[k]) hdr_store[k] = '0;
        endfunction

        function void note_word(logic [7:0] b);
            t_frame_result r;
            logic [15:0]   count;
            r = '0;
            if (in_payload && bytes_left != 0) begin
                r.kind         = KIND_PAYLOAD;
                r.payload_byte = b;
                bytes_left     = bytes_left - 16'd1;
                if (bytes_left == 0) begin
                    r.last     = 1'b1;
                    in_payload = 1'b0;
                end
                pending_results.push_back(r);
                return;
            end
            in_payload = 1'b0;
            if (hdr_idx < HEADER_BYTES - 1) begin
                hdr_store[hdr_idx] = b;
                hdr_idx = hdr_idx + 3'd1;
                return;
            end
            hdr_idx          = '0;
            count            = {hdr_store[6], b};
            r.version        = hdr_store[0];
            r.msg_type       = hdr_store[1][3:0];
            r.msg_flags      = hdr_store[1][7:4];
            r.message_id     = hdr_store[2];
            r.status_code    = hdr_store[3];
            r.transaction_id = {hdr_store[4], hdr_store[5]};
            if (count < HEADER_BYTES) begin
                r.kind = KIND_SHORT;
                r.last = 1'b1;
            end else begin
                r.kind           = KIND_HEADER;
                r.payload_length = count - 16'(HEADER_BYTES);
                if (count == HEADER_BYTES) begin
                    r.last = 1'b1;
                end else begin
                    bytes_left = count - 16'(HEADER_BYTES);
                    in_payload = 1'b1;
                end
            end
            pending_results.push_back(r);
        endfunction

        function void cmp(string name, int unsigned e, int unsigned a);
            if (e != a) begin
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, e, a);
                errors++;
            end
        endfunction

        function void check_result(t_frame_result act);
            t_frame_result e;
            if (pending_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, got %h", $time, act);
                errors++;
                return;
            end
            e = pending_results.pop_front();
            cmp("result_kind", e.kind, act.kind);
            cmp("version", e.version, act.version);
            cmp("msg_type", e.msg_type, act.msg_type);
            cmp("msg_flags", e.msg_flags, act.msg_flags);
            cmp("message_id", e.message_id, act.message_id);
            cmp("status_code", e.status_code, act.status_code);
            cmp("transaction_id", e.transaction_id, act.transaction_id);
            cmp("payload_length", e.payload_length, act.payload_length);
            cmp("payload_byte", e.payload_byte, act.payload_byte);
            cmp("last", e.last, act.last);
        endfunction
    endclass

    logic         i_clk;
    logic         i_rst_n;
    logic         i_valid;
    logic         o_stall;
    logic [7:0]   i_data_byte;
    logic         o_valid;
    logic         i_stall;
    t_result_kind o_result_kind;
    logic [7:0]   o_version;
    logic [3:0]   o_msg_type;
    logic [3:0]   o_msg_flags;
    logic [7:0]   o_message_id;
    logic [7:0]   o_status_code;
    logic [15:0]  o_transaction_id;
    logic [15:0]  o_payload_length;
    logic [7:0]   o_payload_byte;
    logic         o_last;

    FrameScoreboard sb;
    int unsigned    send_idle_pct;
    int unsigned    recv_stall_pct;
    logic           calm;
    int unsigned    words_sent;

    hart_ip_stream_deframer u_top (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_valid          (i_valid),
        .o_stall          (o_stall),
        .i_data_byte      (i_data_byte),
        .o_valid          (o_valid),
        .i_stall          (i_stall),
        .o_result_kind    (o_result_kind),
        .o_version        (o_version),
        .o_msg_type       (o_msg_type),
        .o_msg_flags      (o_msg_flags),
        .o_message_id     (o_message_id),
        .o_status_code    (o_status_code),
        .o_transaction_id (o_transaction_id),
        .o_payload_length (o_payload_length),
        .o_payload_byte   (o_payload_byte),
        .o_last           (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        i_stall <= !calm && ($urandom_range(99) < recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_frame_result act;
        if (i_rst_n && o_valid && !i_stall) begin
            act.kind           = o_result_kind;
            act.version        = o_version;
            act.msg_type       = o_msg_type;
            act.msg_flags      = o_msg_flags;
            act.message_id     = o_message_id;
            act.status_code    = o_status_code;
            act.transaction_id = o_transaction_id;
            act.payload_length = o_payload_length;
            act.payload_byte   = o_payload_byte;
            act.last           = o_last;
            sb.check_result(act);
        end
    end

    // Called at a falling edge; returns at the falling edge after the word is taken.
    task automatic send_word(input logic [7:0] b);
        while (!calm && ($urandom_range(99) < send_idle_pct)) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        do @(posedge i_clk); while (o_stall);
        sb.note_word(b);
        words_sent++;
        @(negedge i_clk);
    endtask

    // Header fields are bytes 0..5 from the top of hdr; payload bytes are random.
    task automatic send_packet(input logic [47:0] hdr, input logic [15:0] count);
        int unsigned n;
        for (int k = 5; k >= 0; k--) send_word(hdr[k*8 +: 8]);
        send_word(count[15:8]);
        send_word(count[7:0]);
        n = (count > HEADER_BYTES) ? count - HEADER_BYTES : 0;
        repeat (n) send_word(8'($urandom()));
    endtask

    function automatic logic [15:0] pick_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 8)  return 16'($urandom_range(HEADER_BYTES - 1));
        if (r < 18) return 16'(HEADER_BYTES);
        if (r < 93) return 16'(HEADER_BYTES + 1 + $urandom_range(31));
        return 16'(HEADER_BYTES + 1 + $urandom_range(299));
    endfunction

    initial begin
        #4_000_000;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        int unsigned phase_start;
        sb             = new();
        i_rst_n        = 1'b0;
        i_valid        = 1'b0;
        i_data_byte    = '0;
        i_stall        = 1'b0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        calm           = 1'b0;
        words_sent     = 0;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Short count with all header bits set, header-only packet with all clear,
        // then a single payload word with alternating nibbles in the header.
        send_packet(48'hFFFF_FFFF_FFFF, 16'h0007);
        send_packet(48'h0000_0000_0000, 16'h0008);
        send_packet(48'h5AA5_C33C_0FF0, 16'h0009);
        // A zero count is also short.
        send_packet(48'hA55A_3CC3_F00F, 16'h0000);
        // A byte count with its high byte set, streamed at full rate.
        send_packet({$urandom(), 16'($urandom())}, 16'h0100);

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 83; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 83; end
                default: begin send_idle_pct = 23; recv_stall_pct = 23; end
            endcase
            phase_start = words_sent;
            while (words_sent - phase_start < 250) begin
                calm = ($urandom_range(7) == 0);
                send_packet({$urandom(), 16'($urandom())}, pick_count());
            end
        end
        calm = 1'b0;
        i_valid <= 1'b0;

        while (sb.pending_results.size() != 0) @(posedge i_clk);
        repeat (16) @(posedge i_clk);

        if (sb.errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
